@@ rtl/core/image_header_dimension_parser_assert.svh @@
// Assertion helpers included by the parser top module.
`ifndef IMAGE_HEADER_DIMENSION_PARSER_ASSERT_SVH
`define IMAGE_HEADER_DIMENSION_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define IHDP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// Next-cycle implication, disabled while in reset.
`define IHDP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

@@ rtl/core/ihdp_pkg.sv @@
package ihdp_pkg;

    typedef enum logic [2:0] {
        FMT_NONE = 3'd0,
        FMT_JPEG = 3'd1,
        FMT_GIF  = 3'd2,
        FMT_PNG  = 3'd3,
        FMT_BMP  = 3'd4
    } ihdp_format_t;

    localparam int HDR_LEN   = 26;
    localparam int HDR_IDX_W = $clog2(HDR_LEN);
    localparam int SEG_W     = 16;
    localparam int DIM_W     = 32;

    localparam logic [7:0] BYTE_MARK  = 8'hFF;
    localparam logic [7:0] BYTE_SOI   = 8'hD8;
    localparam logic [7:0] SOF_BASE0  = 8'hC0;
    localparam logic [7:0] SOF_BASE1  = 8'hC1;
    localparam logic [7:0] SOF_PROG0  = 8'hC2;
    localparam logic [7:0] SOF_LOSS0  = 8'hC3;
    localparam logic [7:0] SOF_ARITH0 = 8'hC9;
    localparam logic [7:0] SOF_ARITH1 = 8'hCA;
    localparam logic [7:0] SOF_ARITH2 = 8'hCB;

    localparam logic [7:0] PNG_SIG [8] = '{8'h89, 8'h50, 8'h4E, 8'h47,
                                           8'h0D, 8'h0A, 8'h1A, 8'h0A};

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } ihdp_beat_t;

    typedef struct packed {
        ihdp_format_t     image_format;
        logic [DIM_W-1:0] image_width;
        logic [DIM_W-1:0] image_height;
    } ihdp_result_t;

endpackage

@@ rtl/core/ihdp_channels.sv @@
interface ihdp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ihdp_dim_if;
    logic        valid;
    logic        ready;
    logic [2:0]  image_format;
    logic [31:0] image_width;
    logic [31:0] image_height;

    modport source (output valid, output image_format, output image_width,
                    output image_height, input ready);
    modport sink   (input valid, input image_format, input image_width,
                    input image_height, output ready);
endinterface

@@ rtl/core/image_header_dimension_parser.sv @@
// Image header dimension parser.
// byte_in carries an image file one beat per byte, in file order, with last_byte
// set on the final byte. dim_out carries at most one beat per file: the format
// (none, JPEG, GIF, PNG, BMP) with raw 32-bit width and height, sent as soon as
// the header fields are complete, or a format-none beat on the final byte when
// the file was truncated, unknown or its JPEG marker chain broke.
// Throughput: one byte per cycle while no result is held back by a stalled
// dim_out. A byte is registered at acceptance and parsed from the input
// register; a result it completes is loaded into the result register when the
// byte advances, and dim_out is driven straight from that register.
// The parse step is a single pass of compares, a counter update and field
// capture between the input and result registers.
// A stalled dim_out holds its beat; byte_in keeps taking bytes that complete no
// result. A byte that would complete a result waits in the input register and
// ready drops until dim_out drains.
// Reset (rst_n low, asynchronous) empties both registers and rearms the parser;
// the parser also rearms by itself after each final byte.
`include "image_header_dimension_parser_assert.svh"

module image_header_dimension_parser
    import ihdp_pkg::*;
#(
    parameter int OFFSET_BITS = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    ihdp_byte_if.sink  byte_in,
    ihdp_dim_if.source dim_out
);

    logic         beat_valid;
    ihdp_beat_t   beat;
    logic         advance;
    logic         slot_free;
    logic         result_valid;
    ihdp_result_t result;

    // Advance the held byte unless it completes a result that the blocked slot
    // cannot take yet.
    assign advance = beat_valid && (slot_free || !result_valid);

    ihdp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_in),
        .advance    (advance),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    ihdp_core #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .beat         (beat),
        .result_valid (result_valid),
        .result       (result)
    );

    ihdp_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && result_valid),
        .result    (result),
        .slot_free (slot_free),
        .dim_out   (dim_out)
    );

    // A failed parse reports zero dimensions.
    `IHDP_ASSERT_IMPL(a_none_zero, clk, rst_n,
        dim_out.valid && dim_out.image_format == FMT_NONE,
        dim_out.image_width == '0 && dim_out.image_height == '0)
    // Only the five defined format codes leave the block.
    `IHDP_ASSERT_IMPL(a_fmt_range, clk, rst_n, dim_out.valid,
        dim_out.image_format <= FMT_BMP)
    // Input backpressure only comes from a held byte.
    `IHDP_ASSERT_IMPL(a_ready_cause, clk, rst_n, !byte_in.ready, beat_valid && !slot_free)
    // A loaded result shows up as a valid beat next cycle.
    `IHDP_ASSERT_NEXT(a_load_shows, clk, rst_n, advance && result_valid, dim_out.valid)

endmodule

@@ rtl/core/ihdp_in_stage.sv @@
module ihdp_in_stage
    import ihdp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    ihdp_byte_if.sink    byte_in,
    input  logic         advance,
    output logic         beat_valid,
    output ihdp_beat_t   beat
);

    logic       valid_reg;
    logic       valid_next;
    ihdp_beat_t beat_reg;

    // Take a new beat when empty or when the held beat moves on.
    assign byte_in.ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (byte_in.valid && byte_in.ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_in.valid && byte_in.ready)
        begin
            beat_reg.data_byte <= byte_in.data_byte;
            beat_reg.last_byte <= byte_in.last_byte;
        end
    end

    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

endmodule

@@ rtl/core/ihdp_core.sv @@
module ihdp_core
    import ihdp_pkg::*;
#(
    parameter int OFFSET_BITS = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         advance,
    input  ihdp_beat_t   beat,
    output logic         result_valid,
    output ihdp_result_t result
);

    typedef enum logic [3:0] {
        PH_SIG,
        PH_MARK1,
        PH_MARK2,
        PH_LENHI,
        PH_LENLO,
        PH_SKIP,
        PH_FRAME,
        PH_DONE
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [SEG_W-1:0]       seg_reg, seg_next;
    logic [15:0]            width_reg, width_next;
    logic [15:0]            height_reg, height_next;
    logic                   sent_reg, sent_next;
    logic [7:0]             hdr_reg [HDR_LEN];

    logic [7:0]             b;
    logic                   emit;
    logic                   png_sig_ok;
    logic                   is_sof;
    logic [15:0]            seg_len;
    logic [SEG_W-1:0]       seg_dec;
    ihdp_result_t           res;

    assign b = beat.data_byte;

    assign is_sof = (b == SOF_BASE0) || (b == SOF_BASE1) || (b == SOF_PROG0) ||
                    (b == SOF_LOSS0) || (b == SOF_ARITH0) || (b == SOF_ARITH1) ||
                    (b == SOF_ARITH2);

    assign seg_len = {seg_reg[7:0], b};
    assign seg_dec = (seg_reg != '0) ? seg_reg - SEG_W'(1) : seg_reg;

    always_comb
    begin
        png_sig_ok = (hdr_reg[12] == 8'h49) && (hdr_reg[13] == 8'h48) &&
                     (hdr_reg[14] == 8'h44) && (hdr_reg[15] == 8'h52);
        for (int i = 0; i < 8; i++)
        begin
            if (hdr_reg[i] != PNG_SIG[i])
            begin
                png_sig_ok = 1'b0;
            end
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        seg_next    = seg_reg;
        width_next  = width_reg;
        height_next = height_reg;
        sent_next   = sent_reg;
        offset_next = (offset_reg == '1) ? offset_reg : offset_reg + OFFSET_BITS'(1);
        emit        = 1'b0;
        res         = '{image_format: FMT_NONE, image_width: '0, image_height: '0};

        case (phase_reg)
            PH_SIG:
            begin
                if (offset_reg == OFFSET_BITS'(2) && hdr_reg[0] == BYTE_MARK &&
                    hdr_reg[1] == BYTE_SOI && b == BYTE_MARK)
                begin
                    phase_next = PH_MARK2;
                end
                else if (offset_reg == OFFSET_BITS'(9) && hdr_reg[0] == 8'h47 &&
                         hdr_reg[1] == 8'h49 && hdr_reg[2] == 8'h46)
                begin
                    emit = 1'b1;
                    res  = '{image_format: FMT_GIF,
                             image_width:  {16'd0, hdr_reg[7], hdr_reg[6]},
                             image_height: {16'd0, b, hdr_reg[8]}};
                end
                else if (offset_reg == OFFSET_BITS'(23) && png_sig_ok)
                begin
                    emit = 1'b1;
                    res  = '{image_format: FMT_PNG,
                             image_width:  {hdr_reg[16], hdr_reg[17], hdr_reg[18], hdr_reg[19]},
                             image_height: {hdr_reg[20], hdr_reg[21], hdr_reg[22], b}};
                end
                else if (offset_reg == OFFSET_BITS'(HDR_LEN - 1) && hdr_reg[0] == 8'h42 &&
                         hdr_reg[1] == 8'h4D)
                begin
                    emit = 1'b1;
                    res  = '{image_format: FMT_BMP,
                             image_width:  {hdr_reg[21], hdr_reg[20], hdr_reg[19], hdr_reg[18]},
                             image_height: {b, hdr_reg[24], hdr_reg[23], hdr_reg[22]}};
                end
                else if (offset_reg >= OFFSET_BITS'(HDR_LEN - 1))
                begin
                    phase_next = PH_DONE;
                end
            end
            PH_MARK1:
            begin
                phase_next = (b == BYTE_MARK) ? PH_MARK2 : PH_DONE;
            end
            PH_MARK2:
            begin
                // Fill bytes keep us waiting for the marker code.
                if (b != BYTE_MARK)
                begin
                    seg_next   = '0;
                    phase_next = is_sof ? PH_FRAME : PH_LENHI;
                end
            end
            PH_LENHI:
            begin
                seg_next   = SEG_W'(b);
                phase_next = PH_LENLO;
            end
            PH_LENLO:
            begin
                if (seg_len < 16'd2)
                begin
                    phase_next = PH_DONE;
                end
                else
                begin
                    seg_next   = seg_len - 16'd2;
                    phase_next = (seg_len == 16'd2) ? PH_MARK1 : PH_SKIP;
                end
            end
            PH_SKIP:
            begin
                seg_next = seg_dec;
                if (seg_dec == '0)
                begin
                    phase_next = PH_MARK1;
                end
            end
            PH_FRAME:
            begin
                // Frame header: length, precision, height, width.
                if (seg_reg == SEG_W'(3) || seg_reg == SEG_W'(4))
                begin
                    height_next = {height_reg[7:0], b};
                end
                if (seg_reg == SEG_W'(5) || seg_reg == SEG_W'(6))
                begin
                    width_next = {width_reg[7:0], b};
                end
                if (seg_reg >= SEG_W'(6))
                begin
                    emit = 1'b1;
                    res  = '{image_format: FMT_JPEG,
                             image_width:  {16'd0, width_reg[7:0], b},
                             image_height: {16'd0, height_reg}};
                end
                else
                begin
                    seg_next = seg_reg + SEG_W'(1);
                end
            end
            PH_DONE:
            begin
                phase_next = PH_DONE;
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase

        if (emit)
        begin
            phase_next = PH_DONE;
            sent_next  = 1'b1;
        end

        result_valid = emit;

        // Final beat: report a failed parse if nothing went out, then rearm.
        if (beat.last_byte)
        begin
            if (!emit && !sent_reg)
            begin
                result_valid = 1'b1;
            end
            offset_next = '0;
            phase_next  = PH_SIG;
            seg_next    = '0;
            sent_next   = 1'b0;
        end

        result = res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SIG;
            offset_reg <= '0;
            seg_reg    <= '0;
            sent_reg   <= 1'b0;
            width_reg  <= '0;
            height_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            offset_reg <= offset_next;
            seg_reg    <= seg_next;
            sent_reg   <= sent_next;
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && phase_reg == PH_SIG && offset_reg < OFFSET_BITS'(HDR_LEN))
        begin
            hdr_reg[offset_reg[HDR_IDX_W-1:0]] <= b;
        end
    end

endmodule

@@ rtl/core/ihdp_out_stage.sv @@
module ihdp_out_stage
    import ihdp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  ihdp_result_t result,
    output logic         slot_free,
    ihdp_dim_if.source   dim_out
);

    logic         valid_reg;
    logic         valid_next;
    ihdp_result_t result_reg;

    assign slot_free = !valid_reg || dim_out.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (dim_out.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign dim_out.valid        = valid_reg;
    assign dim_out.image_format = result_reg.image_format;
    assign dim_out.image_width  = result_reg.image_width;
    assign dim_out.image_height = result_reg.image_height;

endmodule
